[rtl/mma_pkg.sv]
package mma_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_GROUND  = 3'd0;  // no message in progress
  localparam logic [2:0] PH_ONE_ONE = 3'd1;  // waiting for the only data byte
  localparam logic [2:0] PH_ONE_TWO = 3'd2;  // waiting for first of two data bytes
  localparam logic [2:0] PH_TWO_TWO = 3'd3;  // waiting for second of two data bytes
  localparam logic [2:0] PH_SYSEX   = 3'd4;  // inside SysEx, data dropped

  // Status byte fields
  localparam logic [3:0] HI_SYSTEM  = 4'hF;
  localparam logic [3:0] HI_PROG    = 4'hC;
  localparam logic [3:0] HI_CHPRESS = 4'hD;

  // System common low nibble codes (bit 3 clear)
  localparam logic [2:0] SYS_SYSEX  = 3'h0;
  localparam logic [2:0] SYS_MTC    = 3'h1;
  localparam logic [2:0] SYS_SPP    = 3'h2;
  localparam logic [2:0] SYS_SONG   = 3'h3;
  localparam logic [2:0] SYS_UNDEF4 = 3'h4;
  localparam logic [2:0] SYS_UNDEF5 = 3'h5;
  localparam logic [2:0] SYS_TUNE   = 3'h6;
  localparam logic [2:0] SYS_EOX    = 3'h7;

  // Message lengths
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // One assembled message
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
    logic [1:0] length;
  } msg_t;

endpackage

[rtl/mma_parser.sv]
module mma_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        byte_in,
  output logic              res_valid,
  output mma_pkg::msg_t     res
);
  import mma_pkg::*;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] held_status;
  logic [7:0] held_status_next;
  logic [6:0] held_first_data;
  logic [6:0] held_first_data_next;

  // Decode one byte against the held parse state
  always_comb begin
    phase_next           = phase;
    held_status_next     = held_status;
    held_first_data_next = held_first_data;
    res_valid            = 1'b0;
    res.status           = byte_in;
    res.data1            = '0;
    res.data2            = '0;
    res.length           = LEN_ONE;

    if (byte_in[7]) begin
      if (byte_in[7:4] == HI_SYSTEM) begin
        if (byte_in[3]) begin
          // realtime: pass at once, state untouched
          res_valid = 1'b1;
        end else begin
          held_status_next = byte_in;
          unique case (byte_in[2:0])
            SYS_MTC, SYS_SONG: phase_next = PH_ONE_ONE;
            SYS_SPP:           phase_next = PH_ONE_TWO;
            SYS_UNDEF4, SYS_UNDEF5, SYS_TUNE: res_valid = 1'b1;
            SYS_SYSEX:         phase_next = PH_SYSEX;
            SYS_EOX:           phase_next = PH_GROUND;
            default:           phase_next = PH_GROUND;
          endcase
        end
      end else begin
        // channel status
        held_status_next = byte_in;
        if (byte_in[7:4] == HI_PROG || byte_in[7:4] == HI_CHPRESS) begin
          phase_next = PH_ONE_ONE;
        end else begin
          phase_next = PH_ONE_TWO;
        end
      end
    end else begin
      // data byte
      unique case (phase)
        PH_ONE_ONE: begin
          res_valid  = 1'b1;
          res.status = held_status;
          res.data1  = byte_in[6:0];
          res.length = LEN_TWO;
        end
        PH_ONE_TWO: begin
          held_first_data_next = byte_in[6:0];
          phase_next           = PH_TWO_TWO;
        end
        PH_TWO_TWO: begin
          phase_next = PH_ONE_TWO;
          res_valid  = 1'b1;
          res.status = held_status;
          res.data1  = held_first_data;
          res.data2  = byte_in[6:0];
          res.length = LEN_THREE;
        end
        default: ;  // ground, SysEx, unused codes: drop
      endcase
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_GROUND;
      held_status     <= '0;
      held_first_data <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      held_status     <= held_status_next;
      held_first_data <= held_first_data_next;
    end
  end

endmodule

[rtl/mma_out_reg.sv]
module mma_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  mma_pkg::msg_t msg_in,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          free,
  output mma_pkg::msg_t msg_out
);
  import mma_pkg::*;

  // Register can take a new word when empty or being drained
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      msg_out <= msg_in;
    end
  end

endmodule

[rtl/midi_message_assembler.sv]
// MIDI message assembler with running status.
// Input channel: one MIDI byte per word on midi_byte, handshake in_valid /
// in_stall. Output channel: one complete message per word on msg_status,
// msg_data1, msg_data2 and msg_length (1 to 3 valid bytes), handshake
// out_valid / out_stall. Unused data fields read zero.
// Data bytes that complete no message, status bytes that only set up the
// parser, and SysEx payload produce no output word.
// Throughput: one byte per cycle while the input is not stalled. A byte is
// held in the input register, is decoded against the parse state and is
// loaded into the output register as it advances; its message is offered
// from there. The decode lies combinationally between the two registers.
// Reset returns the parser to ground with no status held and empties both
// registers. While out_stall is high the held message stays put; the input
// register keeps draining bytes that produce no output, and stalls the
// input only when a byte with a message finds the output register full.
module midi_message_assembler (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] midi_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] msg_status,
  output logic [6:0] msg_data1,
  output logic [6:0] msg_data2,
  output logic [1:0] msg_length
);
  import mma_pkg::*;

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       advance;
  logic       res_valid;
  logic       out_free;
  msg_t       res;
  msg_t       msg_q;

  // Byte moves into the parser unless its message is blocked
  assign advance  = in_reg_valid && (!res_valid || out_free);
  assign in_stall = in_reg_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= midi_byte;
    end
  end

  mma_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .byte_in   (in_reg_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mma_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .msg_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (out_free),
    .msg_out   (msg_q)
  );

  assign msg_status = msg_q.status;
  assign msg_data1  = msg_q.data1;
  assign msg_data2  = msg_q.data2;
  assign msg_length = msg_q.length;

  // A decoded message always reaches the output register
  a_msg_lands: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid) |=> out_valid)
    else $error("decoded message lost");

  // Output words never carry a zero length
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (msg_length != 2'd0))
    else $error("zero length message");

  // Every message starts with a status byte
  a_status_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> msg_status[7])
    else $error("message without status byte");

  // The input stalls only when a message is blocked by a full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (res_valid && out_valid && out_stall))
    else $error("unexpected input stall");

endmodule
